>>> design/rtch_pkg.sv
`timescale 1ns / 1ps

package rtch_pkg;

    localparam int ANGLE_W  = 9;
    localparam int RADIUS_W = 8;
    localparam int SIZE_W   = 8;
    localparam int OFF_W    = 10;
    localparam int EDGE_W   = 11;
    localparam int E2_W     = 20;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    localparam logic [SIZE_W-1:0] RESET_SHIP_WIDTH  = 8'd16;
    localparam logic [SIZE_W-1:0] RESET_SHIP_HEIGHT = 8'd40;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam longint      Q30_ONE     = longint'(1) <<< 30;

    localparam logic [63:0] SIN_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                            64'd110, 64'd156, 64'd210};
    localparam logic [63:0] COS_DIV [7] = '{64'd2, 64'd12, 64'd30, 64'd56,
                                            64'd90, 64'd132, 64'd182};

    typedef enum logic [0:0] {
        REG_SHIP_WIDTH  = 1'b0,
        REG_SHIP_HEIGHT = 1'b1
    } t_reg_index;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_VERTEX = 2'd1,
        KIND_CENTER = 2'd2,
        KIND_EDGE   = 2'd3
    } t_hit_kind;

    typedef struct packed {
        logic [SIZE_W-1:0] ship_width;
        logic [SIZE_W-1:0] ship_height;
    } t_cfg;

endpackage

>>> design/rtch_if.sv
`timescale 1ns / 1ps

interface rtch_in_if
    import rtch_pkg::*;
#(
    parameter int COORD_BITS = 10
) ();
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] ship_x;
    logic [COORD_BITS-1:0] ship_y;
    logic [ANGLE_W-1:0]    ship_angle;
    logic [COORD_BITS-1:0] rock_x;
    logic [COORD_BITS-1:0] rock_y;
    logic [RADIUS_W-1:0]   rock_radius;

    modport source (output valid, ship_x, ship_y, ship_angle, rock_x, rock_y, rock_radius,
                    input ready);
    modport sink (input valid, ship_x, ship_y, ship_angle, rock_x, rock_y, rock_radius,
                  output ready);
endinterface

interface rtch_out_if ();
    logic       valid;
    logic       ready;
    logic       hit;
    logic [1:0] hit_kind;

    modport source (output valid, hit, hit_kind, input ready);
    modport sink (input valid, hit, hit_kind, output ready);
endinterface

>>> design/rotated_triangle_circle_hit.sv
`timescale 1ns / 1ps

// Triangle versus circle hit test. One transfer per clock is accepted while the
// output is not stalled, and one result per item comes out in order after the
// eight register stages (sine/cosine ROM read, rotation multiply, vertex
// rounding, differences, squared terms, compares, the edge distance multiply,
// result). An output stall backs up only as far as the pipeline is full.
// Heading goes through a 512-entry ROM built at elaboration; ship_width and
// ship_height are written over the APB port at byte offsets 0 and 4.
module rotated_triangle_circle_hit
    import rtch_pkg::*;
#(
    parameter int ANGLE_STEPS    = 360,
    parameter int TRIG_FRAC_BITS = 14,
    parameter int COORD_BITS     = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    rtch_in_if.sink           i_item,
    rtch_out_if.source        o_result
);

    localparam int F         = TRIG_FRAC_BITS;
    localparam int CB        = COORD_BITS;
    localparam int TW        = F + 2;
    localparam int PW        = SIZE_W + TW;
    localparam int VW        = CB + 2;
    localparam int DW        = CB + 3;
    localparam int C2W       = 2 * DW;
    localparam int KW        = DW + EDGE_W + 1;
    localparam int NS        = 8;
    localparam int ROM_DEPTH = 2 ** ANGLE_W;

    localparam logic signed [PW:0] HALF_PIX = (PW+1)'(1) <<< (F - 1);

    typedef logic [2*TW-1:0] t_trig_rom [ROM_DEPTH];

    function automatic longint q30_to_trig(input longint v);
        longint x;
        x = v;
        if (x < 0) x = 0;
        if (x > Q30_ONE) x = Q30_ONE;
        return (x + (longint'(1) <<< (29 - F))) >>> (30 - F);
    endfunction

    function automatic t_trig_rom build_trig_rom();
        t_trig_rom   rom;
        logic [63:0] n4, q, rem, t, t2, term;
        longint      s, c, sn, cs;
        int          idx;
        for (int j = 0; j < ROM_DEPTH; j++) begin
            idx  = j % ANGLE_STEPS;
            n4   = 64'(4 * idx);
            q    = n4 / ANGLE_STEPS;
            rem  = n4 - q * ANGLE_STEPS;
            t    = (HALF_PI_Q30 * rem) / ANGLE_STEPS;
            t2   = (t * t) >> 30;
            term = t;
            s    = longint'(t);
            c    = Q30_ONE;
            for (int k = 1; k <= 7; k++) begin
                term = ((term * t2) >> 30) / SIN_DIV[k-1];
                if (k % 2 == 1) s = s - longint'(term);
                else            s = s + longint'(term);
            end
            term = 64'(Q30_ONE);
            for (int k = 1; k <= 7; k++) begin
                term = ((term * t2) >> 30) / COS_DIV[k-1];
                if (k % 2 == 1) c = c - longint'(term);
                else            c = c + longint'(term);
            end
            s = q30_to_trig(s);
            c = q30_to_trig(c);
            case (q[1:0])
                2'd0:    begin sn = s;  cs = c;  end
                2'd1:    begin sn = c;  cs = -s; end
                2'd2:    begin sn = -s; cs = -c; end
                default: begin sn = -c; cs = s;  end
            endcase
            rom[j] = {TW'(sn), TW'(cs)};
        end
        return rom;
    endfunction

    localparam t_trig_rom TRIG_ROM = build_trig_rom();

    function automatic logic signed [OFF_W-1:0] round_off(input logic signed [PW:0] v);
        logic signed [PW:0] x;
        x = (v + HALF_PIX) >>> F;
        return x[OFF_W-1:0];
    endfunction

    t_cfg w_cfg;

    rtch_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    logic [NS-1:0] r_v;
    logic [NS-1:0] w_en;

    always_comb begin
        w_en[NS-1] = !r_v[NS-1] || o_result.ready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign i_item.ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) r_v[0] <= i_item.valid;
            for (int k = 1; k < NS; k++) begin
                if (w_en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // stage 0: capture, ROM read
    logic [CB-1:0]              r0_sx, r0_sy, r0_rx, r0_ry;
    logic [RADIUS_W-1:0]        r0_r;
    logic signed [SIZE_W-1:0]   r0_hw, r0_hh;
    logic [2*TW-1:0]            r0_trig;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r0_sx   <= i_item.ship_x;
            r0_sy   <= i_item.ship_y;
            r0_rx   <= i_item.rock_x;
            r0_ry   <= i_item.rock_y;
            r0_r    <= i_item.rock_radius;
            r0_hw   <= signed'({1'b0, w_cfg.ship_width[SIZE_W-1:1]});
            r0_hh   <= signed'({1'b0, w_cfg.ship_height[SIZE_W-1:1]});
            r0_trig <= TRIG_ROM[i_item.ship_angle];
        end
    end

    // stage 1: rotation products
    logic signed [TW-1:0]   w_sin, w_cos;
    logic [CB-1:0]          r1_sx, r1_sy, r1_rx, r1_ry;
    logic [RADIUS_W-1:0]    r1_r;
    logic signed [PW-1:0]   r1_a, r1_b, r1_c, r1_d;

    assign w_sin = signed'(r0_trig[2*TW-1:TW]);
    assign w_cos = signed'(r0_trig[TW-1:0]);

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r1_sx <= r0_sx;
            r1_sy <= r0_sy;
            r1_rx <= r0_rx;
            r1_ry <= r0_ry;
            r1_r  <= r0_r;
            r1_a  <= PW'(r0_hw) * PW'(w_cos);
            r1_b  <= PW'(r0_hh) * PW'(w_sin);
            r1_c  <= PW'(r0_hw) * PW'(w_sin);
            r1_d  <= PW'(r0_hh) * PW'(w_cos);
        end
    end

    // stage 2: rounded vertices
    logic signed [OFF_W-1:0] n_ox [3];
    logic signed [OFF_W-1:0] n_oy [3];
    logic signed [VW-1:0]    r2_vx [3];
    logic signed [VW-1:0]    r2_vy [3];
    logic [CB-1:0]           r2_rx, r2_ry;
    logic [2*RADIUS_W-1:0]   r2_r2;

    always_comb begin
        n_ox[0] = round_off((PW+1)'(r1_b));
        n_oy[0] = round_off(-(PW+1)'(r1_d));
        n_ox[1] = round_off((PW+1)'(r1_a) - (PW+1)'(r1_b));
        n_oy[1] = round_off((PW+1)'(r1_c) + (PW+1)'(r1_d));
        n_ox[2] = round_off(-(PW+1)'(r1_a) - (PW+1)'(r1_b));
        n_oy[2] = round_off((PW+1)'(r1_d) - (PW+1)'(r1_c));
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            for (int i = 0; i < 3; i++) begin
                r2_vx[i] <= VW'(signed'({1'b0, r1_sx})) + VW'(n_ox[i]);
                r2_vy[i] <= VW'(signed'({1'b0, r1_sy})) + VW'(n_oy[i]);
            end
            r2_rx <= r1_rx;
            r2_ry <= r1_ry;
            r2_r2 <= (2*RADIUS_W)'(r1_r) * (2*RADIUS_W)'(r1_r);
        end
    end

    // stage 3: offsets from vertices
    logic signed [DW-1:0]     r3_cx [3];
    logic signed [DW-1:0]     r3_cy [3];
    logic signed [EDGE_W-1:0] r3_ex [3];
    logic signed [EDGE_W-1:0] r3_ey [3];
    logic [2*RADIUS_W-1:0]    r3_r2;

    always_ff @(posedge i_clk) begin
        int j;
        if (w_en[3]) begin
            for (int i = 0; i < 3; i++) begin
                j = (i + 1) % 3;
                r3_cx[i] <= DW'(signed'({1'b0, r2_rx})) - DW'(r2_vx[i]);
                r3_cy[i] <= DW'(signed'({1'b0, r2_ry})) - DW'(r2_vy[i]);
                r3_ex[i] <= EDGE_W'(DW'(r2_vx[j]) - DW'(r2_vx[i]));
                r3_ey[i] <= EDGE_W'(DW'(r2_vy[j]) - DW'(r2_vy[i]));
            end
            r3_r2 <= r2_r2;
        end
    end

    // stage 4: squared terms and cross products
    logic signed [C2W-1:0]  r4_c2 [3];
    logic signed [KW-1:0]   r4_cr [3];
    logic signed [KW-1:0]   r4_k  [3];
    logic [E2_W-1:0]        r4_e2 [3];
    logic [2*RADIUS_W-1:0]  r4_r2;
    logic signed [2*EDGE_W-1:0] n_e2 [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_e2[i] = (2*EDGE_W)'(r3_ex[i]) * (2*EDGE_W)'(r3_ex[i])
                    + (2*EDGE_W)'(r3_ey[i]) * (2*EDGE_W)'(r3_ey[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            for (int i = 0; i < 3; i++) begin
                r4_c2[i] <= C2W'(r3_cx[i]) * C2W'(r3_cx[i])
                          + C2W'(r3_cy[i]) * C2W'(r3_cy[i]);
                r4_cr[i] <= KW'(r3_ey[i]) * KW'(r3_cx[i]) - KW'(r3_ex[i]) * KW'(r3_cy[i]);
                r4_k[i]  <= KW'(r3_cx[i]) * KW'(r3_ex[i]) + KW'(r3_cy[i]) * KW'(r3_ey[i]);
                r4_e2[i] <= n_e2[i][E2_W-1:0];
            end
            r4_r2 <= r3_r2;
        end
    end

    // stage 5: compares, edge operands
    logic signed [C2W-1:0]  n_d [3];
    logic                   r5_vert, r5_inside;
    logic [2:0]             r5_kok, r5_dneg, r5_dbig;
    logic [E2_W-1:0]        r5_dd [3];
    logic [E2_W-1:0]        r5_kk [3];
    logic [E2_W-1:0]        r5_e2 [3];
    logic                   n_vert, n_pos, n_neg;

    always_comb begin
        n_vert = 1'b0;
        n_pos  = 1'b1;
        n_neg  = 1'b1;
        for (int i = 0; i < 3; i++) begin
            n_d[i] = r4_c2[i] - C2W'(signed'({1'b0, r4_r2}));
            if (r4_c2[i] <= C2W'(signed'({1'b0, r4_r2}))) n_vert = 1'b1;
            if (r4_cr[i] < 0) n_pos = 1'b0;
            if (r4_cr[i] > 0) n_neg = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r5_vert   <= n_vert;
            r5_inside <= n_pos || n_neg;
            for (int i = 0; i < 3; i++) begin
                r5_kok[i]  <= (r4_k[i] > 0) && (r4_k[i] < KW'(signed'({1'b0, r4_e2[i]})));
                r5_dneg[i] <= n_d[i] < 0;
                r5_dbig[i] <= (n_d[i] >= 0) && ((n_d[i] >>> E2_W) != 0);
                r5_dd[i]   <= n_d[i][E2_W-1:0];
                r5_kk[i]   <= r4_k[i][E2_W-1:0];
                r5_e2[i]   <= r4_e2[i];
            end
        end
    end

    // stage 6: edge distance products
    logic                   r6_vert, r6_inside;
    logic [2:0]             r6_kok, r6_dneg, r6_dbig;
    logic [2*E2_W-1:0]      r6_lhs [3];
    logic [2*E2_W-1:0]      r6_rhs [3];

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r6_vert   <= r5_vert;
            r6_inside <= r5_inside;
            r6_kok    <= r5_kok;
            r6_dneg   <= r5_dneg;
            r6_dbig   <= r5_dbig;
            for (int i = 0; i < 3; i++) begin
                r6_lhs[i] <= (2*E2_W)'(r5_dd[i]) * (2*E2_W)'(r5_e2[i]);
                r6_rhs[i] <= (2*E2_W)'(r5_kk[i]) * (2*E2_W)'(r5_kk[i]);
            end
        end
    end

    // stage 7: result
    t_hit_kind n_kind;
    t_hit_kind r7_kind;
    logic      n_near;

    always_comb begin
        n_near = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (r6_kok[i] && (r6_dneg[i] || (!r6_dbig[i] && r6_lhs[i] <= r6_rhs[i]))) begin
                n_near = 1'b1;
            end
        end
        if (r6_vert)        n_kind = KIND_VERTEX;
        else if (r6_inside) n_kind = KIND_CENTER;
        else if (n_near)    n_kind = KIND_EDGE;
        else                n_kind = KIND_NONE;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[7]) begin
            r7_kind <= n_kind;
        end
    end

    assign o_result.valid    = r_v[NS-1];
    assign o_result.hit      = r7_kind != KIND_NONE;
    assign o_result.hit_kind = r7_kind;

endmodule

>>> design/rtch_cfg.sv
`timescale 1ns / 1ps

module rtch_cfg
    import rtch_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg       r_cfg;
    t_reg_index w_index;

    assign w_index = t_reg_index'(paddr[2]);
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ship_width  <= RESET_SHIP_WIDTH;
            r_cfg.ship_height <= RESET_SHIP_HEIGHT;
        end else if (psel && penable && pwrite) begin
            unique case (w_index)
                REG_SHIP_WIDTH:  r_cfg.ship_width  <= pwdata[SIZE_W-1:0];
                REG_SHIP_HEIGHT: r_cfg.ship_height <= pwdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_index)
            REG_SHIP_WIDTH:  prdata = DATA_W'(r_cfg.ship_width);
            REG_SHIP_HEIGHT: prdata = DATA_W'(r_cfg.ship_height);
            default:         prdata = '0;
        endcase
    end

endmodule
